// ----- hw/rtl/edf_rm_task_picker_top_assert.svh -----
// assertion macros for the edf/rm task picker
// expects i_clk and i_rst_n in the scope of use
`ifndef EDF_RM_TASK_PICKER_TOP_ASSERT_SVH
`define EDF_RM_TASK_PICKER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define EDFRM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, off during reset
`define EDFRM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/edfrm_pkg.sv -----
// shared types and constants for the edf/rm task picker
// no dependencies
`default_nettype none

package edfrm_pkg;

    localparam int RATE_KNEE     = 30;
    localparam int WEIGHT_DIV    = 29;
    localparam int WEIGHT_MUL    = 3;
    localparam int CEILING_RESET = 10000;

    localparam logic [1:0] POL_RR  = 2'd0;
    localparam logic [1:0] POL_EDF = 2'd1;
    localparam logic [1:0] POL_RM  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [15:0] runs;
        logic [5:0]  rate;
        logic [15:0] deadline;
        logic [1:0]  policy;
        logic        ready;
        logic [14:0] pid;
    } t_entry;

    // max(1, ceil(3*(30-rate)/29)) as threshold compares
    function automatic logic [2:0] rm_weight(input logic [5:0] rate);
        logic [6:0] t;
        t = 7'(WEIGHT_MUL) * 7'(RATE_KNEE - int'(rate));
        if (int'(rate) >= RATE_KNEE) begin
            return 3'd1;
        end else if (t <= 7'(WEIGHT_DIV)) begin
            return 3'd1;
        end else if (t <= 7'(2 * WEIGHT_DIV)) begin
            return 3'd2;
        end else if (t <= 7'(3 * WEIGHT_DIV)) begin
            return 3'd3;
        end else begin
            return 3'd4;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/edfrm_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module edfrm_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/edf_rm_task_picker_top.sv -----
// Task picker with a table of ENTRIES tasks held in one ram. A write request
// reads its entry, merges the run count and writes it back. A pick request scans
// the table through the single ram read port, one entry per cycle, and its
// result is loaded into the output register once that register is free.
// After reset a clearing pass writes every entry to zero, during which no
// request is taken; the deadline ceiling may be written anytime the block is
// idle, including during that pass.
// depends on edfrm_pkg, edfrm_ram and edf_rm_task_picker_top_assert.svh
`default_nettype none

`include "edf_rm_task_picker_top_assert.svh"

module edf_rm_task_picker_top
    import edfrm_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slot[5:0] task_pid[20:6] ready_req[21] policy_sel[23:22]
    // abs_deadline[39:24] task_rate[45:40] clear_count[46] pad[47]
    input  wire logic [47:0] i_s_tdata,
    // mode[0]
    input  wire logic [0:0]  i_s_tuser,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // picked_slot[5:0] picked_pid[20:6] policy_used[22:21] run_count[38:23] pad[39]
    output logic      [39:0] o_m_tdata,
    // found[0]
    output logic      [0:0]  o_m_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    t_state r_state, n_state;

    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_cnt;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic          r_best_vld;
    logic [AW-1:0] r_best_idx;
    t_entry        r_best;
    logic [2:0]    r_best_w;
    logic [1:0]    r_pol_used;
    logic          r_edf_seen;
    logic          r_rm_seen;
    logic [AW-1:0] r_rr_ptr;
    logic [15:0]   r_ceiling;
    logic          r_out_vld;
    logic          r_out_found;
    logic [39:0]   r_out_data;

    logic [AW-1:0] r_wr_slot;
    logic [14:0]   r_wr_pid;
    logic          r_wr_ready;
    logic [1:0]    r_wr_policy;
    logic [15:0]   r_wr_deadline;
    logic [5:0]    r_wr_rate;
    logic          r_wr_clear;

    // request fields
    logic [5:0]  req_slot;
    logic        req_mode;
    logic [1:0]  req_policy;
    logic        slot_ok;
    logic        s_acc;

    assign req_mode   = i_s_tuser[0];
    assign req_slot   = i_s_tdata[5:0];
    assign req_policy = i_s_tdata[23:22];
    assign slot_ok    = (32'(req_slot) < ENTRIES);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // ram
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;
    logic [55:0]   mem_rdata_raw;

    edfrm_ram #(
        .WIDTH (56),
        .DEPTH (1 << AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata_raw)
    );

    assign mem_rdata = t_entry'(mem_rdata_raw);

    // scan compare
    logic          issue;
    logic          out_free;
    logic          out_load;
    logic [2:0]    cur_w;
    logic          take;
    logic [15:0]   runs_new;
    logic [AW-1:0] addr_inc;

    assign issue    = (r_state == ST_SCAN) && (r_cnt < CW'(ENTRIES));
    assign out_free = !r_out_vld || i_m_tready;
    assign cur_w    = rm_weight(mem_rdata.rate);
    assign runs_new = (r_best.runs == 16'hFFFF) ? r_best.runs : r_best.runs + 16'd1;
    assign addr_inc = (r_addr == LAST) ? '0 : r_addr + 1'b1;

    always_comb begin
        take = 1'b0;
        if (r_rd_vld && mem_rdata.ready) begin
            case (r_pol_used)
                POL_EDF: begin
                    if (mem_rdata.policy == POL_EDF && mem_rdata.deadline < r_ceiling) begin
                        take = !r_best_vld || (mem_rdata.deadline < r_best.deadline) ||
                               (mem_rdata.deadline == r_best.deadline &&
                                mem_rdata.pid < r_best.pid);
                    end
                end
                POL_RM: begin
                    if (mem_rdata.policy == POL_RM) begin
                        take = !r_best_vld || (cur_w < r_best_w) ||
                               (cur_w == r_best_w && mem_rdata.pid < r_best.pid);
                    end
                end
                default: begin
                    take = (mem_rdata.policy == POL_RR) && !r_best_vld;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_addr == LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_acc) begin
                    if (req_mode) begin
                        n_state = ST_SCAN;
                    end else if (slot_ok) begin
                        n_state = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (r_cnt == CW'(ENTRIES) && !r_rd_vld) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_s_tready = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_addr;
        mem_wdata  = '0;
        mem_raddr  = r_addr;
        out_load   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                mem_raddr  = AW'(req_slot);
            end
            ST_WRITE: begin
                mem_we             = 1'b1;
                mem_waddr          = r_wr_slot;
                mem_wdata.pid      = r_wr_pid;
                mem_wdata.ready    = r_wr_ready;
                mem_wdata.policy   = r_wr_policy;
                mem_wdata.deadline = r_wr_deadline;
                mem_wdata.rate     = r_wr_rate;
                mem_wdata.runs     = r_wr_clear ? 16'd0 : mem_rdata.runs;
            end
            ST_SCAN: begin
                mem_raddr = r_addr;
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    mem_we         = r_best_vld;
                    mem_waddr      = r_best_idx;
                    mem_wdata      = r_best;
                    mem_wdata.runs = runs_new;
                end
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_addr     <= '0;
            r_cnt      <= '0;
            r_rd_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_pol_used <= POL_RR;
            r_edf_seen <= 1'b0;
            r_rm_seen  <= 1'b0;
            r_rr_ptr   <= '0;
            r_ceiling  <= 16'(CEILING_RESET);
            r_out_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (i_cfg_wr_en) r_ceiling <= i_cfg_wr_data;

            if (r_state == ST_CLEAR || issue) begin
                r_addr <= addr_inc;
            end
            if (issue) r_cnt <= r_cnt + 1'b1;
            if (take) r_best_vld <= 1'b1;

            if (s_acc && req_mode) begin
                r_addr     <= (r_edf_seen || r_rm_seen) ? '0 : r_rr_ptr;
                r_cnt      <= '0;
                r_best_vld <= 1'b0;
                r_pol_used <= r_edf_seen ? POL_EDF : (r_rm_seen ? POL_RM : POL_RR);
            end
            if (s_acc && !req_mode && slot_ok) begin
                if (req_policy == POL_EDF) r_edf_seen <= 1'b1;
                if (req_policy == POL_RM) r_rm_seen <= 1'b1;
            end

            if (out_load && r_best_vld && r_pol_used == POL_RR) begin
                r_rr_ptr <= (r_best_idx == LAST) ? '0 : r_best_idx + 1'b1;
            end

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (take) begin
            r_best     <= mem_rdata;
            r_best_idx <= r_rd_idx;
            r_best_w   <= cur_w;
        end
        if (s_acc) begin
            r_wr_slot     <= AW'(req_slot);
            r_wr_pid      <= i_s_tdata[20:6];
            r_wr_ready    <= i_s_tdata[21];
            r_wr_policy   <= req_policy;
            r_wr_deadline <= i_s_tdata[39:24];
            r_wr_rate     <= i_s_tdata[45:40];
            r_wr_clear    <= i_s_tdata[46];
        end
        if (out_load) begin
            r_out_found <= r_best_vld;
            if (r_best_vld) begin
                r_out_data <= {1'b0, runs_new, r_pol_used, r_best.pid, 6'(r_best_idx)};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_found;

    `EDFRM_ASSERT_IMP(a_empty_is_zero, o_m_tvalid && !o_m_tuser[0], o_m_tdata == '0)
    `EDFRM_ASSERT_NXT(a_edf_sticky, r_edf_seen, r_edf_seen)
    `EDFRM_ASSERT_IMP(a_no_write_in_scan, r_state == ST_SCAN, !mem_we)
    `EDFRM_ASSERT_IMP(a_cnt_bound, r_state == ST_SCAN, r_cnt <= CW'(ENTRIES))

endmodule

`default_nettype wire
